FILE: rtl/core/sdo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_pkg
// Shared constants, codes and controller/datapath types of the SDO client.
// ----------------------------------------------------------------------------
package sdo_pkg;

  localparam int BUF_BYTES_DEF = 256;

  localparam int IN_DW  = 112;
  localparam int IN_UW  = 3;
  localparam int OUT_DW = 160;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam int LEN_W  = 9;
  localparam int ET_W   = 17;

  // ops
  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_START_DL = 3'd2;
  localparam logic [2:0] OP_START_UL = 3'd3;
  localparam logic [2:0] OP_PROCESS  = 3'd4;

  // transfer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DL_REQ = 3'd1;
  localparam logic [2:0] PH_DL_RSP = 3'd2;
  localparam logic [2:0] PH_DL_SEG = 3'd3;
  localparam logic [2:0] PH_UL_REQ = 3'd4;
  localparam logic [2:0] PH_UL_RSP = 3'd5;
  localparam logic [2:0] PH_UL_SEG = 3'd6;

  // status
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_SUCCESS = 2'd2;
  localparam logic [1:0] ST_ABORT   = 2'd3;

  // abort codes
  localparam logic [31:0] AB_TIMEOUT = 32'h0504_0000;
  localparam logic [31:0] AB_COMMAND = 32'h0504_0001;
  localparam logic [31:0] AB_MUX     = 32'h0604_0043;
  localparam logic [31:0] AB_TOGGLE  = 32'h0503_0000;
  localparam logic [31:0] AB_MEMORY  = 32'h0504_0005;
  localparam logic [31:0] AB_NOSIZE  = 32'h0607_0010;
  localparam logic [31:0] AB_GENERAL = 32'h0800_0000;

  // command specifiers (top three bits of byte 0)
  localparam logic [2:0] CS_DL_SEG_RSP  = 3'd1;
  localparam logic [2:0] CS_UL_INIT_RSP = 3'd2;
  localparam logic [2:0] CS_DL_INIT_RSP = 3'd3;
  localparam logic [2:0] CS_UL_SEG_RSP  = 3'd0;
  localparam logic [2:0] CS_ABORT       = 3'd4;

  localparam logic [7:0] CMD_ABORT   = 8'h80;
  localparam logic [7:0] CMD_DL_EXP  = 8'h23;
  localparam logic [7:0] CMD_DL_SIZE = 8'h21;
  localparam logic [7:0] CMD_UL_INIT = 8'h40;
  localparam logic [7:0] CMD_UL_SEG  = 8'h60;

  localparam logic [10:0] COB_RSDO = 11'h600;

  // configuration register indexes
  localparam logic [2:0] CFG_NODE    = 3'd0;
  localparam logic [2:0] CFG_INDEX   = 3'd1;
  localparam logic [2:0] CFG_SUB     = 3'd2;
  localparam logic [2:0] CFG_LEN     = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT = 3'd4;
  localparam logic [2:0] CFG_SYNC_TT = 3'd5;
  localparam logic [2:0] CFG_GATED   = 3'd6;
  localparam logic [2:0] CFG_STRICT  = 3'd7;

  typedef struct packed {
    logic       cap_in;
    logic       decide;
    logic       copy_en;
    logic [2:0] copy_idx;
    logic       cap_en;
    logic [2:0] cap_idx;
    logic       load_out;
  } sdo_cmd_t;

  typedef struct packed {
    logic [2:0] job_cnt;
    logic       job_rd;
  } sdo_sts_t;

  function automatic logic [63:0] mux_frame(input logic [7:0] cs, input logic [15:0] idx,
                                            input logic [7:0] sub);
    mux_frame = {32'd0, sub, idx[15:8], idx[7:0], cs};
  endfunction

endpackage

FILE: rtl/core/canopen_sdo_client_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canopen_sdo_client_engine_core
// SDO client (expedited and segmented, with size) over a local byte buffer.
// ----------------------------------------------------------------------------
// One request in, one result out. A request is accepted, then passes through
// the decide state, the copy state (one buffer byte moved per step, up to
// 7 bytes, through the single buffer RAM port), a drain state when bytes are
// read from the buffer, and the done state that hands off the result. Requests
// are handled one at a time; the next request is taken while the previous
// result still waits on the output. Buffer contents are undefined until
// written. Config writes are taken at any time, meant for idle periods.
// ----------------------------------------------------------------------------
module canopen_sdo_client_engine_core
  import sdo_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request: tuser = op[2:0]
  // tdata  = buf_addr[7:0], buf_byte[15:8], rx_valid[16], rx_frame[80:17],
  //          elapsed_ms[96:81], sync_cnt[104:97], sync_ok[105], zero pad
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [IN_UW-1:0]  in_tuser,
  // result: tdata = tx_valid[0], tx_can_id[11:1], tx_frame[75:12],
  //   status[77:76], server_abort_code[109:78], client_abort_code[141:110],
  //   read_data[149:142], received_length[158:150], zero pad
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  // config write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);
  sdo_cmd_t cmd;
  sdo_sts_t sts;

  logic             tx_valid;
  logic [10:0]      tx_can_id;
  logic [63:0]      tx_frame;
  logic [1:0]       status;
  logic [31:0]      sab, cab;
  logic [7:0]       rdata;
  logic [LEN_W-1:0] rlen;

  assign cfg_ready = 1'b1;

  sdo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sdo_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid),
    .cfg_idx           (cfg_index),
    .cfg_wdata         (cfg_data),
    .op                (in_tuser[2:0]),
    .buf_addr          (in_tdata[7:0]),
    .buf_byte          (in_tdata[15:8]),
    .rx_valid          (in_tdata[16]),
    .rx_frame          (in_tdata[80:17]),
    .elapsed_ms        (in_tdata[96:81]),
    .sync_cnt          (in_tdata[104:97]),
    .sync_ok           (in_tdata[105]),
    .tx_valid          (tx_valid),
    .tx_can_id         (tx_can_id),
    .tx_frame          (tx_frame),
    .status            (status),
    .server_abort_code (sab),
    .client_abort_code (cab),
    .read_data         (rdata),
    .received_length   (rlen)
  );

  assign out_tdata = {1'b0, rlen, rdata, cab, sab, status, tx_frame, tx_can_id, tx_valid};
endmodule

FILE: rtl/core/sdo_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/sdo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_ctrl
// Request sequencer: accept, decide, buffer copy, result hand-off.
// ----------------------------------------------------------------------------
module sdo_ctrl
  import sdo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  sdo_sts_t sts,
  output sdo_cmd_t cmd
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [2:0] k_r, k_nxt;
  logic       outv_r, outv_nxt;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = outv_r;

  always_comb begin
    st_nxt   = st_r;
    k_nxt    = k_r;
    outv_nxt = outv_r && !out_tready;
    cmd      = '0;
    cmd.cap_in   = in_tvalid && in_tready;
    cmd.copy_idx = k_r;
    cmd.cap_idx  = k_r - 3'd1;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          st_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        k_nxt      = 3'd0;
        st_nxt     = S_COPY;
      end
      S_COPY: begin
        if (sts.job_cnt == 3'd0) begin
          st_nxt = S_DONE;
        end else begin
          cmd.copy_en = 1'b1;
          cmd.cap_en  = sts.job_rd && (k_r != 3'd0);
          k_nxt       = k_r + 3'd1;
          if (k_r == sts.job_cnt - 3'd1) begin
            st_nxt = sts.job_rd ? S_DRAIN : S_DONE;
          end
        end
      end
      S_DRAIN: begin
        cmd.cap_en = 1'b1;
        st_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!outv_r || out_tready) begin
          cmd.load_out = 1'b1;
          outv_nxt     = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      k_r    <= 3'd0;
      outv_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      k_r    <= k_nxt;
      outv_r <= outv_nxt;
    end
  end
endmodule

FILE: rtl/core/sdo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_dp
// SDO protocol registers, frame build/check, timer and byte buffer.
// ----------------------------------------------------------------------------
module sdo_dp
  import sdo_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sdo_cmd_t          cmd,
  output sdo_sts_t          sts,
  // config
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // request fields
  input  logic [2:0]        op,
  input  logic [7:0]        buf_addr,
  input  logic [7:0]        buf_byte,
  input  logic              rx_valid,
  input  logic [63:0]       rx_frame,
  input  logic [15:0]       elapsed_ms,
  input  logic [7:0]        sync_cnt,
  input  logic              sync_ok,
  // result fields
  output logic              tx_valid,
  output logic [10:0]       tx_can_id,
  output logic [63:0]       tx_frame,
  output logic [1:0]        status,
  output logic [31:0]       server_abort_code,
  output logic [31:0]       client_abort_code,
  output logic [7:0]        read_data,
  output logic [LEN_W-1:0]  received_length
);
  localparam int AW = $clog2(BUF_BYTES);

  // config registers
  logic [6:0]       node_r;
  logic [15:0]      idx_r;
  logic [7:0]       sub_r;
  logic [LEN_W-1:0] len_r;
  logic [15:0]      tmo_r;
  logic [7:0]       stt_r;
  logic             gated_r, strict_r;

  // latched request
  logic [2:0]  op_r;
  logic [7:0]  addr_r, byte_r, sc_r;
  logic        rxv_r, sok_r;
  logic [63:0] rxf_r;
  logic [15:0] el_r;

  // protocol state
  logic [2:0]       phase_r, phase_nxt;
  logic             pend_r, pend_nxt, tog_r, tog_nxt, trun_r, trun_nxt;
  logic [LEN_W-1:0] off_r, off_nxt, tot_r, tot_nxt;
  logic [ET_W-1:0]  et_r, et_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [31:0]      sab_r, sab_nxt, cab_r, cab_nxt;

  // frame under construction and copy job
  logic             txv_r, txv_nxt;
  logic [63:0]      txf_r, txf_nxt;
  logic [7:0]       rd_r;
  logic [2:0]       jcnt_r, jcnt_nxt, jlane_r, jlane_nxt;
  logic [LEN_W-1:0] jbase_r, jbase_nxt;
  logic             jwr_r, jwr_nxt, jrd_r, jrd_nxt, jrdd_r, jrdd_nxt;
  logic             wop_we;

  // result register
  logic             o_txv;
  logic [10:0]      o_id;
  logic [63:0]      o_txf;
  logic [1:0]       o_stat;
  logic [31:0]      o_sab, o_cab;
  logic [7:0]       o_rd;
  logic [LEN_W-1:0] o_len;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wd, ram_q;
  logic [LEN_W:0] cp_addr;
  logic [2:0]    cp_lane, cap_lane;

  assign sts.job_cnt = jcnt_r;
  assign sts.job_rd  = jrd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r   <= 7'd1;
      idx_r    <= '0;
      sub_r    <= '0;
      len_r    <= '0;
      tmo_r    <= '0;
      stt_r    <= '0;
      gated_r  <= 1'b0;
      strict_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NODE:    node_r   <= cfg_wdata[6:0];
        CFG_INDEX:   idx_r    <= cfg_wdata;
        CFG_SUB:     sub_r    <= cfg_wdata[7:0];
        CFG_LEN:     len_r    <= cfg_wdata[LEN_W-1:0];
        CFG_TIMEOUT: tmo_r    <= cfg_wdata;
        CFG_SYNC_TT: stt_r    <= cfg_wdata[7:0];
        CFG_GATED:   gated_r  <= cfg_wdata[0];
        CFG_STRICT:  strict_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r   <= op;
      addr_r <= buf_addr;
      byte_r <= buf_byte;
      rxv_r  <= rx_valid;
      rxf_r  <= rx_frame;
      el_r   <= elapsed_ms;
      sc_r   <= sync_cnt;
      sok_r  <= sync_ok;
    end
  end

  // decision for one request
  always_comb begin
    logic [7:0]       cs;
    logic [LEN_W-1:0] eff, d;
    logic [ET_W:0]    et_sum;
    logic [31:0]      rx_hi;
    logic             do_ab, timed, mux_ok, exp_len, last, in_rng;
    logic [31:0]      ab_code;
    logic [2:0]       n;
    logic             dl_seg;
    logic             seg_tog;

    cs      = rxf_r[7:0];
    rx_hi   = rxf_r[63:32];
    eff     = (32'(len_r) > 32'(BUF_BYTES)) ? LEN_W'(BUF_BYTES) : len_r;
    mux_ok  = (rxf_r[23:8] == idx_r) && (rxf_r[31:24] == sub_r);
    exp_len = (tot_r >= 9'd1) && (tot_r <= 9'd4);
    in_rng  = (32'(addr_r) < 32'(BUF_BYTES));
    et_sum  = {1'b0, et_r} + {{(ET_W-15){1'b0}}, el_r};
    do_ab   = 1'b0;
    ab_code = '0;
    timed   = 1'b0;
    dl_seg  = 1'b0;
    seg_tog = tog_r;
    d       = '0;
    last    = 1'b0;
    n       = '0;

    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    tog_nxt   = tog_r;
    trun_nxt  = trun_r;
    off_nxt   = off_r;
    tot_nxt   = tot_r;
    et_nxt    = et_r;
    stat_nxt  = stat_r;
    sab_nxt   = sab_r;
    cab_nxt   = cab_r;
    txv_nxt   = 1'b0;
    txf_nxt   = '0;
    jcnt_nxt  = '0;
    jlane_nxt = '0;
    jbase_nxt = '0;
    jwr_nxt   = 1'b0;
    jrd_nxt   = 1'b0;
    jrdd_nxt  = 1'b0;
    wop_we    = 1'b0;

    case (op_r)
      OP_WRITE: wop_we = in_rng;
      OP_READ: begin
        if (in_rng) begin
          jcnt_nxt  = 3'd1;
          jbase_nxt = {1'b0, addr_r};
          jrd_nxt   = 1'b1;
          jrdd_nxt  = 1'b1;
        end
      end
      OP_START_DL, OP_START_UL: begin
        stat_nxt  = ST_BUSY;
        pend_nxt  = 1'b1;
        phase_nxt = (op_r == OP_START_DL) ? PH_DL_REQ : PH_UL_REQ;
      end
      OP_PROCESS: begin
        if (phase_r != PH_IDLE) begin
          if (trun_r) begin
            et_nxt = et_sum[ET_W] ? {ET_W{1'b1}} : et_sum[ET_W-1:0];
            if (et_nxt > {1'b0, tmo_r}) begin
              do_ab   = 1'b1;
              ab_code = AB_TIMEOUT;
              timed   = 1'b1;
            end
          end
          if (!timed) begin
            if (gated_r && !(sok_r && (sc_r == stt_r))) begin
              stat_nxt = ST_BUSY;
            end else if (rxv_r && (cs[7:5] == CS_ABORT)) begin
              trun_nxt  = 1'b0;
              et_nxt    = '0;
              sab_nxt   = rx_hi;
              phase_nxt = PH_IDLE;
              stat_nxt  = ST_ABORT;
            end else if (rxv_r || pend_r) begin
              if (rxv_r) begin
                trun_nxt = 1'b0;
                et_nxt   = '0;
              end
              case (phase_r)
                PH_DL_REQ: begin
                  tog_nxt  = 1'b0;
                  off_nxt  = '0;
                  tot_nxt  = eff;
                  if ((eff >= 9'd1) && (eff <= 9'd4)) begin
                    txf_nxt = mux_frame(CMD_DL_EXP | {4'd0, 2'(3'd4 - eff[2:0]), 2'b00},
                                        idx_r, sub_r);
                    jcnt_nxt  = eff[2:0];
                    jlane_nxt = 3'd4;
                    jrd_nxt   = 1'b1;
                  end else begin
                    txf_nxt = mux_frame(CMD_DL_SIZE, idx_r, sub_r);
                    txf_nxt[63:32] = {23'd0, eff};
                  end
                  txv_nxt   = 1'b1;
                  trun_nxt  = 1'b1;
                  et_nxt    = '0;
                  pend_nxt  = 1'b0;
                  phase_nxt = PH_DL_RSP;
                  stat_nxt  = ST_BUSY;
                end
                PH_DL_RSP: begin
                  if (cs[7:5] != CS_DL_INIT_RSP) begin
                    do_ab = 1'b1; ab_code = AB_COMMAND;
                  end else if (!mux_ok) begin
                    do_ab = 1'b1; ab_code = AB_MUX;
                  end else if (exp_len) begin
                    phase_nxt = PH_IDLE;
                    stat_nxt  = ST_SUCCESS;
                  end else begin
                    dl_seg  = 1'b1;
                    seg_tog = tog_r;
                  end
                end
                PH_DL_SEG: begin
                  if (cs[7:5] != CS_DL_SEG_RSP) begin
                    do_ab = 1'b1; ab_code = AB_COMMAND;
                  end else if (cs[4] != tog_r) begin
                    do_ab = 1'b1; ab_code = AB_TOGGLE;
                  end else begin
                    tog_nxt = !tog_r;
                    if (tot_r <= off_r) begin
                      phase_nxt = PH_IDLE;
                      stat_nxt  = ST_SUCCESS;
                    end else begin
                      dl_seg  = 1'b1;
                      seg_tog = !tog_r;
                    end
                  end
                end
                PH_UL_REQ: begin
                  tog_nxt   = 1'b0;
                  off_nxt   = '0;
                  txf_nxt   = mux_frame(CMD_UL_INIT, idx_r, sub_r);
                  txv_nxt   = 1'b1;
                  trun_nxt  = 1'b1;
                  et_nxt    = '0;
                  pend_nxt  = 1'b0;
                  phase_nxt = PH_UL_RSP;
                  stat_nxt  = ST_BUSY;
                end
                PH_UL_RSP: begin
                  if (cs[7:5] != CS_UL_INIT_RSP) begin
                    do_ab = 1'b1; ab_code = AB_COMMAND;
                  end else if (!mux_ok) begin
                    do_ab = 1'b1; ab_code = AB_MUX;
                  end else if (cs[1:0] == 2'b11) begin
                    n = 3'd4 - {1'b0, cs[3:2]};
                    if (strict_r && (eff < {6'd0, n})) begin
                      do_ab = 1'b1; ab_code = AB_MEMORY;
                    end else begin
                      jcnt_nxt  = n;
                      jlane_nxt = 3'd4;
                      jwr_nxt   = 1'b1;
                      tot_nxt   = {6'd0, n};
                      off_nxt   = {6'd0, n};
                      phase_nxt = PH_IDLE;
                      stat_nxt  = ST_SUCCESS;
                    end
                  end else if (cs[1:0] == 2'b01) begin
                    if ((rx_hi > 32'(BUF_BYTES)) || (strict_r && (rx_hi > 32'(eff)))) begin
                      do_ab = 1'b1; ab_code = AB_MEMORY;
                    end else begin
                      tot_nxt   = rx_hi[LEN_W-1:0];
                      off_nxt   = '0;
                      txf_nxt   = {56'd0, CMD_UL_SEG};
                      txv_nxt   = 1'b1;
                      trun_nxt  = 1'b1;
                      et_nxt    = '0;
                      phase_nxt = PH_UL_SEG;
                      stat_nxt  = ST_BUSY;
                    end
                  end else begin
                    do_ab = 1'b1; ab_code = AB_NOSIZE;
                  end
                end
                PH_UL_SEG: begin
                  if (cs[7:5] != CS_UL_SEG_RSP) begin
                    do_ab = 1'b1; ab_code = AB_COMMAND;
                  end else if (cs[4] != tog_r) begin
                    do_ab = 1'b1; ab_code = AB_TOGGLE;
                  end else begin
                    tog_nxt = !tog_r;
                    if ({1'b0, tot_r} <= ({1'b0, off_r} + 10'd7)) begin
                      if (strict_r && !cs[0]) begin
                        do_ab = 1'b1; ab_code = AB_GENERAL;
                      end else begin
                        jcnt_nxt  = 3'(tot_r - off_r);
                        jbase_nxt = off_r;
                        jlane_nxt = 3'd1;
                        jwr_nxt   = 1'b1;
                        off_nxt   = tot_r;
                        phase_nxt = PH_IDLE;
                        stat_nxt  = ST_SUCCESS;
                      end
                    end else if (strict_r && cs[0]) begin
                      do_ab = 1'b1; ab_code = AB_GENERAL;
                    end else begin
                      jcnt_nxt  = 3'd7;
                      jbase_nxt = off_r;
                      jlane_nxt = 3'd1;
                      jwr_nxt   = 1'b1;
                      off_nxt   = off_r + 9'd7;
                      txf_nxt   = {56'd0, CMD_UL_SEG | {3'd0, !tog_r, 4'd0}};
                      txv_nxt   = 1'b1;
                      trun_nxt  = 1'b1;
                      et_nxt    = '0;
                      stat_nxt  = ST_BUSY;
                    end
                  end
                end
                default: phase_nxt = PH_IDLE;
              endcase
            end else begin
              stat_nxt = ST_BUSY;
            end
          end
        end
      end
      default: ;
    endcase

    // next download segment
    if (dl_seg) begin
      d    = (tot_r > off_r) ? (tot_r - off_r) : '0;
      last = (d <= 9'd7);
      n    = last ? d[2:0] : 3'd7;
      txf_nxt   = {56'd0, 3'd0, seg_tog, (last ? {3'(3'd7 - n), 1'b1} : 4'd0)};
      txv_nxt   = 1'b1;
      jcnt_nxt  = n;
      jbase_nxt = off_r;
      jlane_nxt = 3'd1;
      jrd_nxt   = 1'b1;
      off_nxt   = off_r + {6'd0, n};
      trun_nxt  = 1'b1;
      et_nxt    = '0;
      phase_nxt = PH_DL_SEG;
      stat_nxt  = ST_BUSY;
    end

    if (do_ab) begin
      txf_nxt        = mux_frame(CMD_ABORT, idx_r, sub_r);
      txf_nxt[63:32] = ab_code;
      txv_nxt        = 1'b1;
      cab_nxt        = ab_code;
      trun_nxt       = 1'b0;
      et_nxt         = '0;
      phase_nxt      = PH_IDLE;
      stat_nxt       = ST_ABORT;
      jcnt_nxt       = '0;
      jrd_nxt        = 1'b0;
      jwr_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= 1'b0;
      tog_r   <= 1'b0;
      trun_r  <= 1'b0;
      off_r   <= '0;
      tot_r   <= '0;
      et_r    <= '0;
      stat_r  <= ST_IDLE;
      sab_r   <= '0;
      cab_r   <= '0;
      jcnt_r  <= '0;
      jrd_r   <= 1'b0;
    end else if (cmd.decide) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      tog_r   <= tog_nxt;
      trun_r  <= trun_nxt;
      off_r   <= off_nxt;
      tot_r   <= tot_nxt;
      et_r    <= et_nxt;
      stat_r  <= stat_nxt;
      sab_r   <= sab_nxt;
      cab_r   <= cab_nxt;
      jcnt_r  <= jcnt_nxt;
      jrd_r   <= jrd_nxt;
    end
  end

  // copy lanes
  assign cp_addr  = {1'b0, jbase_r} + {{(LEN_W-2){1'b0}}, cmd.copy_idx};
  assign cp_lane  = jlane_r + cmd.copy_idx;
  assign cap_lane = jlane_r + cmd.cap_idx;

  assign ram_we   = (cmd.decide && wop_we) || (cmd.copy_en && jwr_r);
  assign ram_addr = cmd.decide ? AW'(addr_r) : AW'(cp_addr);
  assign ram_wd   = cmd.decide ? byte_r : rxf_r[8*cp_lane +: 8];

  sdo_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      txv_r   <= txv_nxt;
      txf_r   <= txf_nxt;
      rd_r    <= '0;
      jlane_r <= jlane_nxt;
      jbase_r <= jbase_nxt;
      jwr_r   <= jwr_nxt;
      jrdd_r  <= jrdd_nxt;
    end else if (cmd.cap_en) begin
      if (jrdd_r) begin
        rd_r <= ram_q;
      end else begin
        txf_r[8*cap_lane +: 8] <= ram_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_txv  <= txv_r;
      o_id   <= txv_r ? (COB_RSDO + {4'd0, node_r}) : '0;
      o_txf  <= txf_r;
      o_stat <= stat_r;
      o_sab  <= sab_r;
      o_cab  <= cab_r;
      o_rd   <= rd_r;
      o_len  <= off_r;
    end
  end

  assign tx_valid          = o_txv;
  assign tx_can_id         = o_id;
  assign tx_frame          = o_txf;
  assign status            = o_stat;
  assign server_abort_code = o_sab;
  assign client_abort_code = o_cab;
  assign read_data         = o_rd;
  assign received_length   = o_len;
endmodule
